// ===== src/nptq_pkg.sv =====
package nptq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int TAG_W  = 4;
    localparam int PRIO_W = 8;
    localparam int KIND_W = 3;
    localparam int OCC_W  = 5;

    localparam logic OP_RAISE    = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_STARTED     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESUMED     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IDLE        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DROPPED     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NOT_RUNNING = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic exec;    // apply the accepted word to the queue
        logic report;  // examine the head and load the result register
    } nptq_cmd_t;

endpackage

// ===== src/nptq_if.sv =====
interface nptq_in_if;
    import nptq_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [TAG_W-1:0]  task_tag;
    logic [PRIO_W-1:0] task_priority;

    modport source (output valid, operation, task_tag, task_priority, input ready);
    modport sink   (input valid, operation, task_tag, task_priority, output ready);
endinterface

interface nptq_out_if;
    import nptq_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [TAG_W-1:0]  result_tag;
    logic [PRIO_W-1:0] result_priority;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, result_kind, result_tag, result_priority, occupancy,
                    input ready);
    modport sink   (input valid, result_kind, result_tag, result_priority, occupancy,
                    output ready);
endinterface

// ===== src/nptq_ctrl.sv =====
module nptq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output nptq_pkg::nptq_cmd_t cmd
);
    import nptq_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REPORT = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.exec   = in_valid && in_ready;
    assign cmd.report = (state_reg == ST_REPORT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.exec)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                // hold here while the previous result is still unread
                if (cmd.report)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.report)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_report_only_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |-> (state_reg == ST_REPORT))
        else $error("report issued outside report state");

    a_exec_leads_to_report: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (state_reg == ST_REPORT) && !in_ready)
        else $error("accepted word not followed by report state");

    a_report_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> out_valid)
        else $error("result word not presented after report");

endmodule

// ===== src/nptq_dp.sv =====
module nptq_dp #(
    parameter int QUEUE_DEPTH = nptq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nptq_pkg::nptq_cmd_t          cmd,
    input  logic                         operation,
    input  logic [nptq_pkg::TAG_W-1:0]   task_tag,
    input  logic [nptq_pkg::PRIO_W-1:0]  task_priority,
    output logic [nptq_pkg::KIND_W-1:0]  result_kind,
    output logic [nptq_pkg::TAG_W-1:0]   result_tag,
    output logic [nptq_pkg::PRIO_W-1:0]  result_priority,
    output logic [nptq_pkg::OCC_W-1:0]   occupancy
);
    import nptq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [TAG_W-1:0]  tag_q  [QUEUE_DEPTH];
    logic [PRIO_W-1:0] prio_q [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] run_q;
    logic [CW-1:0]     count_reg;

    logic              fault_reg;
    logic [KIND_W-1:0] fault_kind_reg;
    logic [TAG_W-1:0]  fault_tag_reg;
    logic [PRIO_W-1:0] fault_prio_reg;

    logic [KIND_W-1:0] res_kind_reg;
    logic [TAG_W-1:0]  res_tag_reg;
    logic [PRIO_W-1:0] res_prio_reg;
    logic [OCC_W-1:0]  res_occ_reg;

    logic [QUEUE_DEPTH-1:0] gt;       // cell lies behind the insertion point
    logic [QUEUE_DEPTH-1:0] take_up;  // cell takes its upper neighbour's word
    logic [TAG_W-1:0]  tag_up  [QUEUE_DEPTH];
    logic [PRIO_W-1:0] prio_up [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] run_up;
    logic [TAG_W-1:0]  tag_dn  [QUEUE_DEPTH];
    logic [PRIO_W-1:0] prio_dn [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] run_dn;

    logic full;
    logic do_insert;
    logic do_pop;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign do_insert = cmd.exec && (operation == OP_RAISE) && !full;
    assign do_pop    = cmd.exec && (operation == OP_COMPLETE) && (count_reg != '0) && run_q[0];

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            // empty cells count as larger than any priority
            assign gt[i] = (CW'(i) >= count_reg) || (prio_q[i] > task_priority);

            if (i == 0)
            begin : g_first
                assign take_up[i] = 1'b0;
                assign tag_up[i]  = task_tag;
                assign prio_up[i] = task_priority;
                assign run_up[i]  = 1'b0;
            end
            else
            begin : g_rest
                assign take_up[i] = gt[i-1];
                assign tag_up[i]  = tag_q[i-1];
                assign prio_up[i] = prio_q[i-1];
                assign run_up[i]  = run_q[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign tag_dn[i]  = '0;
                assign prio_dn[i] = '0;
                assign run_dn[i]  = 1'b0;
            end
            else
            begin : g_inner
                assign tag_dn[i]  = tag_q[i+1];
                assign prio_dn[i] = prio_q[i+1];
                assign run_dn[i]  = run_q[i+1];
            end

            always_ff @(posedge clk)
            begin
                if (do_insert && gt[i])
                begin
                    tag_q[i]  <= take_up[i] ? tag_up[i]  : task_tag;
                    prio_q[i] <= take_up[i] ? prio_up[i] : task_priority;
                end
                else if (do_pop)
                begin
                    tag_q[i]  <= tag_dn[i];
                    prio_q[i] <= prio_dn[i];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    run_q[i] <= 1'b0;
                end
                else if (do_insert && gt[i])
                begin
                    run_q[i] <= take_up[i] && run_up[i];
                end
                else if (do_pop)
                begin
                    run_q[i] <= run_dn[i];
                end
                else if (cmd.report && (i == 0) && !fault_reg && (count_reg != '0))
                begin
                    run_q[i] <= 1'b1;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (do_insert)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (do_pop)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    // error outcomes are settled at accept time and held until the report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            fault_reg <= !(do_insert || do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (operation == OP_RAISE)
            begin
                fault_kind_reg <= KIND_DROPPED;
                fault_tag_reg  <= task_tag;
                fault_prio_reg <= task_priority;
            end
            else
            begin
                fault_kind_reg <= KIND_NOT_RUNNING;
                fault_tag_reg  <= (count_reg == '0) ? '0 : tag_q[0];
                fault_prio_reg <= (count_reg == '0) ? '0 : prio_q[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            res_occ_reg <= OCC_W'(count_reg);
            if (fault_reg)
            begin
                res_kind_reg <= fault_kind_reg;
                res_tag_reg  <= fault_tag_reg;
                res_prio_reg <= fault_prio_reg;
            end
            else if (count_reg == '0)
            begin
                res_kind_reg <= KIND_IDLE;
                res_tag_reg  <= '0;
                res_prio_reg <= '0;
            end
            else
            begin
                res_kind_reg <= run_q[0] ? KIND_RESUMED : KIND_STARTED;
                res_tag_reg  <= tag_q[0];
                res_prio_reg <= prio_q[0];
            end
        end
    end

    assign result_kind     = res_kind_reg;
    assign result_tag      = res_tag_reg;
    assign result_priority = res_prio_reg;
    assign occupancy       = res_occ_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_empty_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (run_q == '0))
        else $error("running flag set on empty queue");

    a_head_runs_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.report && !fault_reg && (count_reg != '0)) |=> run_q[0])
        else $error("head not marked running after report");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (prio_q[0] <= prio_q[1]))
        else $error("queue head out of priority order");

endmodule

// ===== src/nested_priority_task_queue_top.sv =====
// Sorted queue of pending interrupt tasks with nested preemption.
// task_in carries one word per event: operation (raise or complete), task_tag
// and task_priority; a smaller priority number wins, equal priorities queue in
// arrival order. result_out returns exactly one word per accepted word: kind
// (started, resumed, idle, dropped, complete without running), the head tag
// and priority (or the dropped task), and the occupancy after the event.
// A word accepted at an edge is applied to the queue at that edge; its result
// is registered in the report state once the result register is free, and
// is valid from then on. A new task word is accepted only after the previous
// word's head examination; the insert itself is a single compare-and-shift
// across all cells in parallel.
// Stall: the result register holds its word until result_out.ready; the next
// task word may be accepted meanwhile, its own result then waits in the
// report state until the register is free.
// Reset: rst_n clears occupancy and all running flags; the queue is empty and
// task_in.ready is high right after reset.
module nested_priority_task_queue_top #(
    parameter int QUEUE_DEPTH = nptq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    nptq_in_if.sink           task_in,
    nptq_out_if.source        result_out
);
    import nptq_pkg::*;

    nptq_cmd_t cmd;

    nptq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (task_in.valid),
        .in_ready  (task_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .cmd       (cmd)
    );

    nptq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .operation       (task_in.operation),
        .task_tag        (task_in.task_tag),
        .task_priority   (task_in.task_priority),
        .result_kind     (result_out.result_kind),
        .result_tag      (result_out.result_tag),
        .result_priority (result_out.result_priority),
        .occupancy       (result_out.occupancy)
    );

endmodule

// ===== verif/tb.sv =====
module tb;
    import nptq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
    } task_result_t;

    logic clk;
    logic rst_n;

    nptq_in_if  task_in ();
    nptq_out_if result_out ();

    nested_priority_task_queue_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_in    (task_in),
        .result_out (result_out)
    );

    // shadow of the pending-task queue
    logic [TAG_W-1:0]  shadow_tag  [DEPTH];
    logic [PRIO_W-1:0] shadow_prio [DEPTH];
    logic              shadow_run  [DEPTH];
    int                shadow_count;

    task_result_t expected_results [$];
    task_result_t observed;
    task_result_t wanted;

    int  mismatches;
    int  cycle_count;
    int  sink_hold_cycles;
    int  sink_stall_left;
    bit  src_idle_en;
    bit  sink_idle_en;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic task_result_t report_head();
        task_result_t r;
        r.occ = OCC_W'(shadow_count);
        if (shadow_count == 0)
        begin
            r.kind = KIND_IDLE;
            r.tag  = '0;
            r.prio = '0;
        end
        else
        begin
            r.kind = shadow_run[0] ? KIND_RESUMED : KIND_STARTED;
            r.tag  = shadow_tag[0];
            r.prio = shadow_prio[0];
            shadow_run[0] = 1'b1;
        end
        return r;
    endfunction

    function automatic task_result_t apply_task_event(input logic op,
                                                      input logic [TAG_W-1:0] tg,
                                                      input logic [PRIO_W-1:0] pr);
        task_result_t r;
        int pos;
        if (op == OP_RAISE)
        begin
            if (shadow_count >= DEPTH)
            begin
                r.kind = KIND_DROPPED;
                r.tag  = tg;
                r.prio = pr;
                r.occ  = OCC_W'(shadow_count);
                return r;
            end
            // after every entry of equal or smaller number, so equal ones stay in order
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] <= pr)
                pos++;
            for (int i = shadow_count; i > pos; i--)
            begin
                shadow_tag[i]  = shadow_tag[i-1];
                shadow_prio[i] = shadow_prio[i-1];
                shadow_run[i]  = shadow_run[i-1];
            end
            shadow_tag[pos]  = tg;
            shadow_prio[pos] = pr;
            shadow_run[pos]  = 1'b0;
            shadow_count++;
            return report_head();
        end
        if (shadow_count == 0 || !shadow_run[0])
        begin
            r.kind = KIND_NOT_RUNNING;
            r.tag  = (shadow_count == 0) ? '0 : shadow_tag[0];
            r.prio = (shadow_count == 0) ? '0 : shadow_prio[0];
            r.occ  = OCC_W'(shadow_count);
            return r;
        end
        for (int i = 1; i < shadow_count; i++)
        begin
            shadow_tag[i-1]  = shadow_tag[i];
            shadow_prio[i-1] = shadow_prio[i];
            shadow_run[i-1]  = shadow_run[i];
        end
        shadow_count--;
        shadow_run[shadow_count] = 1'b0;
        return report_head();
    endfunction

    // one word on task_in; valid stays high into the next word unless a gap is drawn
    task automatic send_word(input logic op, input logic [TAG_W-1:0] tg,
                             input logic [PRIO_W-1:0] pr);
        int gap;
        gap = 0;
        if (src_idle_en && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            task_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        task_in.valid         <= 1'b1;
        task_in.operation     <= op;
        task_in.task_tag      <= tg;
        task_in.task_priority <= pr;
        @(posedge clk);
        while (!task_in.ready)
            @(posedge clk);
        expected_results.push_back(apply_task_event(op, tg, pr));
    endtask

    task automatic random_event(input int raise_pct);
        logic              op;
        logic [PRIO_W-1:0] pr;
        op = ($urandom_range(0, 99) < raise_pct) ? OP_RAISE : OP_COMPLETE;
        // cluster some priorities at the ends so ties and preemption turn up often
        case ($urandom_range(0, 3))
            1:       pr = PRIO_W'($urandom_range(0, 3));
            2:       pr = PRIO_W'($urandom_range(252, 255));
            default: pr = PRIO_W'($urandom_range(0, 255));
        endcase
        send_word(op, TAG_W'($urandom_range(0, 15)), pr);
    endtask

    task automatic check_directed_cases();
        send_word(OP_COMPLETE, 4'd0, 8'd0);      // nothing queued
        send_word(OP_RAISE, 4'd0, 8'd255);
        send_word(OP_RAISE, 4'd15, 8'd0);        // preempts
        send_word(OP_RAISE, 4'd10, 8'd0);        // tie, queues behind
        send_word(OP_COMPLETE, 4'd3, 8'd9);
        send_word(OP_COMPLETE, 4'd3, 8'd9);
        send_word(OP_COMPLETE, 4'd3, 8'd9);      // back to idle
        for (int i = 0; i < DEPTH; i++)
            send_word(OP_RAISE, TAG_W'(i), (i % 4 == 0) ? 8'd128 : PRIO_W'(i * 53));
        send_word(OP_RAISE, 4'd15, 8'd0);        // full
        send_word(OP_RAISE, 4'd0, 8'd255);
    endtask

    task automatic run_random_events(input int n);
        int sent;
        int phase_len;
        int raise_pct;
        sent = 0;
        while (sent < n)
        begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       raise_pct = 85;
                1:       raise_pct = 50;
                default: raise_pct = 15;
            endcase
            for (int i = 0; i < phase_len && sent < n; i++)
            begin
                random_event(raise_pct);
                sent++;
            end
        end
    endtask

    task automatic fill_under_stall();
        src_idle_en      = 1'b0;
        sink_hold_cycles = 200;
        for (int i = 0; i < 60; i++)
            random_event(75);
        src_idle_en = 1'b1;
    endtask

    task automatic stream_without_gaps();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (int i = 0; i < 250; i++)
            random_event((i < 125) ? 70 : 30);
    endtask

    // receiver: random stall bursts, plus a long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                result_out.ready <= 1'b0;
                sink_hold_cycles--;
            end
            else if (sink_stall_left > 0)
            begin
                result_out.ready <= 1'b0;
                sink_stall_left--;
            end
            else
            begin
                result_out.ready <= 1'b1;
                if (sink_idle_en && $urandom_range(0, 11) == 0)
                    sink_stall_left = $urandom_range(1, 19);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_out.valid && result_out.ready)
        begin
            observed.kind = result_out.result_kind;
            observed.tag  = result_out.result_tag;
            observed.prio = result_out.result_priority;
            observed.occ  = result_out.occupancy;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected word kind=%0d tag=%0d prio=%0d occ=%0d",
                             observed.kind, observed.tag, observed.prio, observed.occ);
            end
            else
            begin
                wanted = expected_results.pop_front();
                if (observed.kind !== wanted.kind || observed.tag !== wanted.tag ||
                    observed.prio !== wanted.prio || observed.occ !== wanted.occ)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch exp kind=%0d tag=%0d prio=%0d occ=%0d",
                                 wanted.kind, wanted.tag, wanted.prio, wanted.occ,
                                 ", got kind=%0d tag=%0d prio=%0d occ=%0d",
                                 observed.kind, observed.tag, observed.prio, observed.occ);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        task_in.valid         = 1'b0;
        task_in.operation     = OP_RAISE;
        task_in.task_tag      = '0;
        task_in.task_priority = '0;
        result_out.ready      = 1'b0;
        shadow_count          = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_tag[i]  = '0;
            shadow_prio[i] = '0;
            shadow_run[i]  = 1'b0;
        end
        mismatches       = 0;
        cycle_count      = 0;
        sink_hold_cycles = 0;
        sink_stall_left  = 0;
        src_idle_en      = 1'b1;
        sink_idle_en     = 1'b1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_directed_cases();
        run_random_events(1350);
        fill_under_stall();
        stream_without_gaps();
        task_in.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== nested_priority_task_queue_top.f =====
src/nptq_pkg.sv
src/nptq_if.sv
src/nptq_ctrl.sv
src/nptq_dp.sv
src/nested_priority_task_queue_top.sv
verif/tb.sv
